// ===== rtl/tprb_pkg.sv =====
package tprb_pkg;

  localparam int COEF_BITS  = 24;
  localparam int COEF_FRAC  = 22;
  localparam int GAIN_FRAC  = 20;
  localparam int DECAY_FRAC = 24;
  localparam int MAX_BLOCK  = 4096;

  localparam int CMD_BITS   = 3;
  localparam int IDX_BITS   = 8;
  localparam int ACT_BITS   = 9;
  localparam int BLEN_BITS  = 13;
  localparam int BCNT_BITS  = 12;
  localparam int THR_BITS   = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;

  localparam int DEF_MAX_FILTERS = 256;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_STATE_BITS  = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLEN   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 2'd2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SAMPLE  = 3'd0,
    CMD_COEF    = 3'd1,
    CMD_STRIKE  = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_SQUELCH = 3'd4
  } cmd_e;

  // coefficient store entry, gain in the low bits
  typedef struct packed {
    logic [COEF_BITS-1:0] decay;
    logic [COEF_BITS-1:0] strike;
    logic [COEF_BITS-1:0] fb2;
    logic [COEF_BITS-1:0] fb1;
    logic [COEF_BITS-1:0] gain;
  } coef_t;

  typedef struct packed {
    logic valid;
    cmd_e op;
  } dp_ctl_t;

endpackage

// ===== rtl/two_pole_resonator_bank.sv =====
// channel   dir  beat contents (lsb first)
// s_axis    in   tuser: cmd; tdata: filter_index, sample_in, coef_in_gain,
//                coef_fb1, coef_fb2, strike_gain, decay_scale
// m_axis    out  tdata: sample_out; tuser: clipped
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// a sample walks the n active filters, or skips the walk with none: one state
// and one coefficient memory read per cycle feed a four-stage multiply pipeline
// a flush check adds a pointer wrap by repeated subtraction
// after reset a clearing pass zeroes every entry of the state memory
// the next beat is taken while a result waits; a new result waits for the slot
module two_pole_resonator_bank #(
  parameter int MAX_FILTERS = tprb_pkg::DEF_MAX_FILTERS,
  parameter int SAMPLE_BITS = tprb_pkg::DEF_SAMPLE_BITS,
  parameter int STATE_BITS  = tprb_pkg::DEF_STATE_BITS,
  localparam int DIN_W  = ((tprb_pkg::IDX_BITS + SAMPLE_BITS + 5 * tprb_pkg::COEF_BITS + 7)
                           / 8) * 8,
  localparam int DOUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // filter_index, sample_in, coef_in_gain, coef_fb1, coef_fb2, strike_gain, decay_scale
  input  logic [DIN_W-1:0]                   s_axis_tdata,
  // cmd
  input  logic [tprb_pkg::CMD_BITS-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sample_out
  output logic [DOUT_W-1:0]                  m_axis_tdata,
  // clipped
  output logic                               m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [tprb_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [tprb_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import tprb_pkg::*;

  localparam int ADDR_BITS = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int CNT_W     = $clog2(MAX_FILTERS + 1);
  localparam int SUMW      = STATE_BITS + ADDR_BITS + 1;
  localparam int NW        = CNT_W + ACT_BITS;
  localparam logic signed [SUMW-1:0] OUT_HI =
    (SUMW'(1) <<< (SAMPLE_BITS - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] OUT_LO = ~OUT_HI;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_WALK, ST_DRAIN, ST_MOD, ST_FLUSH_RD, ST_FLUSH_CK,
    ST_OUT, ST_CLEAR
  } state_e;

  // beat fields
  logic [IDX_BITS-1:0]           in_idx;
  logic signed [SAMPLE_BITS-1:0] in_amp;
  coef_t                         in_coef;
  cmd_e                          in_cmd;

  assign in_idx         = s_axis_tdata[IDX_BITS-1:0];
  assign in_amp         = s_axis_tdata[IDX_BITS +: SAMPLE_BITS];
  assign in_coef        = s_axis_tdata[IDX_BITS + SAMPLE_BITS +: 5 * COEF_BITS];
  assign in_cmd         = cmd_e'(s_axis_tuser);

  // configuration
  logic [ACT_BITS-1:0]  act_q;
  logic [BLEN_BITS-1:0] blen_q;
  logic [THR_BITS-1:0]  thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      blen_q <= BLEN_BITS'(64);
      thr_q  <= THR_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACTIVE: act_q  <= cfg_data_i[ACT_BITS-1:0];
        REG_BLEN:   blen_q <= cfg_data_i[BLEN_BITS-1:0];
        REG_THRESH: thr_q  <= cfg_data_i[THR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [CNT_W-1:0] n_live;
  assign n_live = (NW'(act_q) > NW'(MAX_FILTERS)) ? CNT_W'(MAX_FILTERS)
                                                  : CNT_W'(NW'(act_q));

  // memories
  logic [2*STATE_BITS-1:0] st_mem [MAX_FILTERS];
  coef_t                   cf_mem [MAX_FILTERS];
  logic [2*STATE_BITS-1:0] st_rd_q;
  coef_t                   cf_rd_q;
  logic [ADDR_BITS-1:0]    rd_addr;
  logic                    st_we, cf_we;
  logic [ADDR_BITS-1:0]    st_wa, cf_wa;
  logic [2*STATE_BITS-1:0] st_wd;
  coef_t                   cf_wd;

  always_ff @(posedge clk_i) begin
    st_rd_q <= st_mem[rd_addr];
    cf_rd_q <= cf_mem[rd_addr];
    if (st_we) st_mem[st_wa] <= st_wd;
    if (cf_we) cf_mem[cf_wa] <= cf_wd;
  end

  // sequencer state
  state_e                   st_q;
  logic [CNT_W-1:0]         cnt_q, n_q, mod_q;
  cmd_e                     cmd_q;
  logic signed [SAMPLE_BITS-1:0] amp_q;
  logic signed [SUMW-1:0]   sum_q;
  logic [ADDR_BITS-1:0]     ptr_q;
  logic [BCNT_BITS-1:0]     bcnt_q;
  dp_ctl_t                  iss_q;
  logic                     m_valid_q, clip_q;
  logic signed [SAMPLE_BITS-1:0] out_q;
  logic [ADDR_BITS-1:0]     iss_addr_q;

  dp_ctl_t                      wb_ctl;
  logic [ADDR_BITS-1:0]         wb_addr;
  logic signed [STATE_BITS-1:0] wb_y1, wb_y2;
  coef_t                        wb_coef;
  logic                         dp_busy;

  tprb_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .STATE_BITS (STATE_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ctl_i (iss_q),
    .in_addr_i(iss_addr_q),
    .in_y1_i  (st_rd_q[STATE_BITS-1:0]),
    .in_y2_i  (st_rd_q[2*STATE_BITS-1:STATE_BITS]),
    .in_coef_i(cf_rd_q),
    .amp_i    (amp_q),
    .wb_ctl_o (wb_ctl),
    .wb_addr_o(wb_addr),
    .wb_y1_o  (wb_y1),
    .wb_y2_o  (wb_y2),
    .wb_coef_o(wb_coef),
    .busy_o   (dp_busy)
  );

  logic accept;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE);

  // flush check on the stored entry
  logic signed [STATE_BITS-1:0] fy1, fy2, thr_pos, thr_neg;
  logic                         below_thr;
  assign fy1       = st_rd_q[STATE_BITS-1:0];
  assign fy2       = st_rd_q[2*STATE_BITS-1:STATE_BITS];
  assign thr_pos   = STATE_BITS'($signed({1'b0, thr_q}));
  assign thr_neg   = -thr_pos;
  assign below_thr = (fy1 < thr_pos) && (fy1 > thr_neg) && (fy2 < thr_pos) && (fy2 > thr_neg);

  logic [BLEN_BITS-1:0] bl_eff;
  assign bl_eff = (blen_q == '0) ? BLEN_BITS'(1)
                : ((blen_q > BLEN_BITS'(MAX_BLOCK)) ? BLEN_BITS'(MAX_BLOCK) : blen_q);

  // memory port selection
  always_comb begin
    rd_addr = (st_q == ST_FLUSH_RD) ? ptr_q : cnt_q[ADDR_BITS-1:0];
    st_we = 1'b0;
    st_wa = cnt_q[ADDR_BITS-1:0];
    st_wd = '0;
    cf_we = 1'b0;
    cf_wa = wb_addr;
    cf_wd = wb_coef;
    if (st_q == ST_INIT || st_q == ST_CLEAR) begin
      st_we = 1'b1;
    end else if (st_q == ST_FLUSH_CK) begin
      st_we = below_thr;
      st_wa = ptr_q;
    end else if (wb_ctl.valid && (wb_ctl.op == CMD_SAMPLE || wb_ctl.op == CMD_STRIKE)) begin
      st_we = 1'b1;
      st_wa = wb_addr;
      st_wd = {wb_y2, wb_y1};
    end else if (accept && in_cmd == CMD_COEF) begin
      st_we = (32'(in_idx) < 32'(MAX_FILTERS)) && (ACT_BITS'(in_idx) >= act_q);
      st_wa = ADDR_BITS'(in_idx);
    end
    if (wb_ctl.valid && wb_ctl.op == CMD_SQUELCH) begin
      cf_we = 1'b1;
    end else if (accept && in_cmd == CMD_COEF) begin
      cf_we = (32'(in_idx) < 32'(MAX_FILTERS));
      cf_wa = ADDR_BITS'(in_idx);
      cf_wd = in_coef;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_addr_q <= cnt_q[ADDR_BITS-1:0];
    if (accept) amp_q <= in_amp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_INIT;
      cnt_q     <= '0;
      n_q       <= '0;
      mod_q     <= '0;
      cmd_q     <= CMD_SAMPLE;
      sum_q     <= '0;
      ptr_q     <= '0;
      bcnt_q    <= '0;
      iss_q     <= '0;
      m_valid_q <= 1'b0;
      clip_q    <= 1'b0;
      out_q     <= '0;
    end else begin
      iss_q.valid <= (st_q == ST_WALK);
      iss_q.op    <= cmd_q;
      if (m_valid_q && m_axis_tready && st_q != ST_OUT) m_valid_q <= 1'b0;
      if (wb_ctl.valid && wb_ctl.op == CMD_SAMPLE) sum_q <= sum_q + SUMW'(wb_y1);
      case (st_q)
        ST_INIT: begin
          if (cnt_q == CNT_W'(MAX_FILTERS - 1)) begin
            cnt_q <= '0;
            st_q  <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= in_cmd;
            n_q   <= n_live;
            cnt_q <= '0;
            sum_q <= '0;
            case (in_cmd)
              CMD_SAMPLE: st_q <= (n_live == '0) ? ST_DRAIN : ST_WALK;
              CMD_STRIKE, CMD_SQUELCH: if (n_live != '0) st_q <= ST_WALK;
              CMD_CLEAR: if (n_live != '0) st_q <= ST_CLEAR;
              default: begin
              end
            endcase
          end
        end
        ST_WALK: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == n_q - CNT_W'(1)) st_q <= ST_DRAIN;
        end
        ST_CLEAR: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == n_q - CNT_W'(1)) st_q <= ST_IDLE;
        end
        ST_DRAIN: begin
          if (!iss_q.valid && !dp_busy && !(st_q == ST_WALK)) begin
            if (cmd_q != CMD_SAMPLE) begin
              st_q <= ST_IDLE;
            end else if (BLEN_BITS'(bcnt_q) + BLEN_BITS'(1) >= bl_eff) begin
              bcnt_q <= '0;
              mod_q  <= CNT_W'(ptr_q) + CNT_W'(1);
              st_q   <= (n_q == '0) ? ST_OUT : ST_MOD;
            end else begin
              bcnt_q <= bcnt_q + BCNT_BITS'(1);
              st_q   <= ST_OUT;
            end
          end
        end
        ST_MOD: begin
          // pointer wrap by repeated subtraction
          if (mod_q >= n_q) begin
            mod_q <= mod_q - n_q;
          end else begin
            ptr_q <= mod_q[ADDR_BITS-1:0];
            st_q  <= ST_FLUSH_RD;
          end
        end
        ST_FLUSH_RD: st_q <= ST_FLUSH_CK;
        ST_FLUSH_CK: st_q <= ST_OUT;
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            if (sum_q > OUT_HI) begin
              out_q  <= OUT_HI[SAMPLE_BITS-1:0];
              clip_q <= 1'b1;
            end else if (sum_q < OUT_LO) begin
              out_q  <= OUT_LO[SAMPLE_BITS-1:0];
              clip_q <= 1'b1;
            end else begin
              out_q  <= sum_q[SAMPLE_BITS-1:0];
              clip_q <= 1'b0;
            end
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = DOUT_W'($unsigned(out_q));
  assign m_axis_tuser  = clip_q;

  // a new beat is only taken once the pipeline is empty
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!dp_busy && !iss_q.valid))
    else $error("beat taken with filter pipeline busy");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WALK) |-> (cnt_q < n_q))
    else $error("walk index beyond active count");

  a_flush_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FLUSH_RD) |-> (CNT_W'(ptr_q) < n_q))
    else $error("flush pointer beyond active count");

  a_wb_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_ctl.valid |-> (st_q == ST_WALK || st_q == ST_DRAIN))
    else $error("write-back outside a walk");

endmodule

// ===== rtl/tprb_datapath.sv =====
module tprb_datapath #(
  parameter int SAMPLE_BITS = tprb_pkg::DEF_SAMPLE_BITS,
  parameter int STATE_BITS  = tprb_pkg::DEF_STATE_BITS,
  parameter int ADDR_BITS   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tprb_pkg::dp_ctl_t             in_ctl_i,
  input  logic [ADDR_BITS-1:0]          in_addr_i,
  input  logic signed [STATE_BITS-1:0]  in_y1_i,
  input  logic signed [STATE_BITS-1:0]  in_y2_i,
  input  tprb_pkg::coef_t               in_coef_i,
  input  logic signed [SAMPLE_BITS-1:0] amp_i,
  output tprb_pkg::dp_ctl_t             wb_ctl_o,
  output logic [ADDR_BITS-1:0]          wb_addr_o,
  output logic signed [STATE_BITS-1:0]  wb_y1_o,
  output logic signed [STATE_BITS-1:0]  wb_y2_o,
  output tprb_pkg::coef_t               wb_coef_o,
  output logic                          busy_o
);
  import tprb_pkg::*;

  localparam int AW  = COEF_BITS + 1;
  localparam int T1  = (STATE_BITS > SAMPLE_BITS) ? STATE_BITS : SAMPLE_BITS;
  localparam int OBW = (T1 > AW) ? T1 : AW;
  localparam int PW  = AW + OBW;
  localparam int SW  = PW + 2;

  localparam logic signed [SW-1:0] RND_C = SW'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [SW-1:0] RND_G = SW'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [SW-1:0] RND_D = SW'(1) <<< (DECAY_FRAC - 1);
  localparam logic signed [SW-1:0] ST_HI = (SW'(1) <<< (STATE_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] ST_LO = ~ST_HI;
  localparam logic signed [SW-1:0] CF_HI = (SW'(1) <<< (COEF_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] CF_LO = ~CF_HI;

  // stage 1: three multipliers on the memory read data and the input sample
  logic signed [AW-1:0]  a1, a2, a3;
  logic signed [OBW-1:0] b1, b2, b3;
  logic signed [PW-1:0]  m1_d, m2_d, m3_d;

  always_comb begin
    a1 = AW'($signed(in_coef_i.fb1));
    b1 = OBW'(in_y1_i);
    a2 = AW'($signed(in_coef_i.fb2));
    b2 = OBW'(in_y2_i);
    a3 = AW'($signed(in_coef_i.gain));
    b3 = OBW'(amp_i);
    case (in_ctl_i.op)
      CMD_STRIKE: begin
        a1 = AW'($signed(in_coef_i.strike));
        b1 = OBW'(amp_i);
      end
      CMD_SQUELCH: begin
        b1 = OBW'($signed({1'b0, in_coef_i.decay}));
        a2 = $signed({1'b0, in_coef_i.decay});
        b2 = OBW'($signed({1'b0, in_coef_i.decay}));
      end
      default: begin
      end
    endcase
  end

  assign m1_d = PW'(a1) * PW'(b1);
  assign m2_d = PW'(a2) * PW'(b2);
  assign m3_d = PW'(a3) * PW'(b3);

  dp_ctl_t                s2_ctl_q, s3_ctl_q, s4_ctl_q;
  logic [ADDR_BITS-1:0]   s2_addr_q, s3_addr_q, s4_addr_q;
  logic signed [STATE_BITS-1:0] s2_y1_q, s2_y2_q, s3_y1_q, s3_y2_q, s4_y1_q, s4_y2_q;
  coef_t                  s2_coef_q, s3_coef_q, s4_coef_q;
  logic signed [PW-1:0]   m1_q, m2_q, m3_q, m4_q;
  logic signed [AW-1:0]   d2_q;

  // stage 2: round, add and saturate
  logic signed [SW-1:0]   tot, ysh, add, ysum, b1r, d2r;
  logic signed [STATE_BITS-1:0] y1_d, y2_d;
  logic signed [AW-1:0]   d2_d;
  coef_t                  coef2_d;

  always_comb begin
    tot  = SW'(m1_q) + SW'(m2_q) + SW'(m3_q) + RND_C;
    ysh  = tot >>> COEF_FRAC;
    add  = (SW'(m1_q) + RND_G) >>> GAIN_FRAC;
    ysum = add + SW'(s2_y1_q);
    b1r  = (SW'(m1_q) + RND_D) >>> DECAY_FRAC;
    d2r  = (SW'(m2_q) + RND_D) >>> DECAY_FRAC;
    y1_d = s2_y1_q;
    y2_d = s2_y2_q;
    d2_d = d2r[AW-1:0];
    coef2_d = s2_coef_q;
    case (s2_ctl_q.op)
      CMD_SAMPLE: begin
        y2_d = s2_y1_q;
        if (ysh > ST_HI) y1_d = ST_HI[STATE_BITS-1:0];
        else if (ysh < ST_LO) y1_d = ST_LO[STATE_BITS-1:0];
        else y1_d = ysh[STATE_BITS-1:0];
      end
      CMD_STRIKE: begin
        if (ysum > ST_HI) y1_d = ST_HI[STATE_BITS-1:0];
        else if (ysum < ST_LO) y1_d = ST_LO[STATE_BITS-1:0];
        else y1_d = ysum[STATE_BITS-1:0];
      end
      CMD_SQUELCH: begin
        if (b1r > CF_HI) coef2_d.fb1 = CF_HI[COEF_BITS-1:0];
        else if (b1r < CF_LO) coef2_d.fb1 = CF_LO[COEF_BITS-1:0];
        else coef2_d.fb1 = b1r[COEF_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  // stage 3: b2 times squared decay
  logic signed [PW-1:0] m4_d;
  assign m4_d = PW'(AW'($signed(s3_coef_q.fb2))) * PW'(d2_q);

  // stage 4: final rounding of b2
  logic signed [SW-1:0] b2r;
  assign b2r = (SW'(m4_q) + RND_D) >>> DECAY_FRAC;

  always_comb begin
    wb_coef_o = s4_coef_q;
    if (b2r > CF_HI) wb_coef_o.fb2 = CF_HI[COEF_BITS-1:0];
    else if (b2r < CF_LO) wb_coef_o.fb2 = CF_LO[COEF_BITS-1:0];
    else wb_coef_o.fb2 = b2r[COEF_BITS-1:0];
  end

  assign wb_ctl_o  = s4_ctl_q;
  assign wb_addr_o = s4_addr_q;
  assign wb_y1_o   = s4_y1_q;
  assign wb_y2_o   = s4_y2_q;
  assign busy_o    = s2_ctl_q.valid | s3_ctl_q.valid | s4_ctl_q.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
      s4_ctl_q <= '0;
    end else begin
      s2_ctl_q <= in_ctl_i;
      s3_ctl_q <= s2_ctl_q;
      s4_ctl_q <= s3_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_addr_q <= in_addr_i;
    s2_y1_q   <= in_y1_i;
    s2_y2_q   <= in_y2_i;
    s2_coef_q <= in_coef_i;
    m1_q      <= m1_d;
    m2_q      <= m2_d;
    m3_q      <= m3_d;
    s3_addr_q <= s2_addr_q;
    s3_y1_q   <= y1_d;
    s3_y2_q   <= y2_d;
    s3_coef_q <= coef2_d;
    d2_q      <= d2_d;
    s4_addr_q <= s3_addr_q;
    s4_y1_q   <= s3_y1_q;
    s4_y2_q   <= s3_y2_q;
    s4_coef_q <= s3_coef_q;
    m4_q      <= m4_d;
  end

endmodule

// ===== tb/two_pole_resonator_bank_tb.sv =====
`timescale 1ns / 1ps

module two_pole_resonator_bank_tb;
  import tprb_pkg::*;

  localparam int NFILT    = 256;
  localparam int DIN_W    = 152;
  localparam int WD_LIMIT = 20000;
  localparam int SETTLE   = 700;

  typedef struct packed {
    logic [23:0] value;
    logic        clip;
  } mix_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  cmd;
    int          idx;
    int          x;
    int          a;
    int          b1;
    int          b2;
    int          sg;
    int          dc;
    bit          typed;
    int          exp_val;
    bit          exp_clip;
    logic [1:0]  reg_sel;
    int          reg_val;
  } row_t;

  typedef struct {
    int act;
    int blen;
    int thr;
    int sidle;
    int rstall;
    int n;
  } phase_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DIN_W-1:0] s_axis_tdata = '0;
  logic [2:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;
  logic             m_axis_tuser;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = '0;
  logic [12:0]      cfg_data_i = '0;

  two_pole_resonator_bank u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // bank model
  longint      y1_st[NFILT], y2_st[NFILT];
  longint      gain_c[NFILT], fb1_c[NFILT], fb2_c[NFILT], strike_c[NFILT], decay_c[NFILT];
  int unsigned flush_ptr, blk_cnt, act_cnt, blk_len, thr_lsb;

  mix_t mix_q[$];
  int   errors = 0;
  int   mismatches = 0;
  int   mixes_seen = 0;
  int   beats_sent = 0;
  int   cfg_writes = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  int   quiet = 0;

  function automatic longint sat_to(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // applies one accepted beat to the model, returns 1 with the mix for a sample
  function automatic bit bank_step(logic [2:0] cmd, logic [DIN_W-1:0] d, output mix_t m);
    int unsigned idx, n, bl, p;
    longint amp, s, y, sum, t, d2;
    idx = d[7:0];
    amp = longint'($signed(d[31:8]));
    n = (act_cnt > NFILT) ? NFILT : act_cnt;
    m = '0;
    case (cmd)
      CMD_COEF: begin
        gain_c[idx]   = longint'($signed(d[55:32]));
        fb1_c[idx]    = longint'($signed(d[79:56]));
        fb2_c[idx]    = longint'($signed(d[103:80]));
        strike_c[idx] = longint'($signed(d[127:104]));
        decay_c[idx]  = longint'(d[151:128]);
        if (idx >= act_cnt) begin
          y1_st[idx] = 0;
          y2_st[idx] = 0;
        end
        return 0;
      end
      CMD_STRIKE: begin
        for (int i = 0; i < n; i++)
          y1_st[i] = sat_to(y1_st[i] + rnd_shift(amp * strike_c[i], GAIN_FRAC), 32);
        return 0;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < n; i++) begin
          y1_st[i] = 0;
          y2_st[i] = 0;
        end
        return 0;
      end
      CMD_SQUELCH: begin
        for (int i = 0; i < n; i++) begin
          d2 = rnd_shift(decay_c[i] * decay_c[i], DECAY_FRAC);
          fb1_c[i] = sat_to(rnd_shift(fb1_c[i] * decay_c[i], DECAY_FRAC), COEF_BITS);
          fb2_c[i] = sat_to(rnd_shift(fb2_c[i] * d2, DECAY_FRAC), COEF_BITS);
        end
        return 0;
      end
      CMD_SAMPLE: begin
        sum = 0;
        for (int i = 0; i < n; i++) begin
          s = fb1_c[i] * y1_st[i] + fb2_c[i] * y2_st[i] + gain_c[i] * amp;
          y = sat_to(rnd_shift(s, COEF_FRAC), 32);
          y2_st[i] = y1_st[i];
          y1_st[i] = y;
          sum += y;
        end
        m.value = 24'(sat_to(sum, 24));
        m.clip = (sat_to(sum, 24) != sum);
        bl = blk_len;
        if (bl == 0) bl = 1;
        if (bl > MAX_BLOCK) bl = MAX_BLOCK;
        if (blk_cnt + 1 >= bl) begin
          blk_cnt = 0;
          if (n > 0) begin
            t = thr_lsb;
            p = (flush_ptr + 1) % n;
            flush_ptr = p;
            if (y1_st[p] < t && y1_st[p] > -t && y2_st[p] < t && y2_st[p] > -t) begin
              y1_st[p] = 0;
              y2_st[p] = 0;
            end
          end
        end else begin
          blk_cnt++;
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [DIN_W-1:0] pack_beat(int idx, int x, int a, int b1, int b2,
                                                 int sg, int dc);
    return {24'(dc), 24'(sg), 24'(b2), 24'(b1), 24'(a), 24'(x), 8'(idx)};
  endfunction

  // poles inside the unit circle for most writes
  function automatic logic [DIN_W-1:0] stable_coef(int idx);
    return pack_beat(idx, $urandom, $urandom_range(131072) - 65536,
                     $urandom_range(10000000) - 5000000,
                     -int'($urandom_range(4194303, 2097152)),
                     $urandom, $urandom_range(16777215, 14000000));
  endfunction

  task automatic send_beat(logic [2:0] cmd, logic [DIN_W-1:0] d, bit typed = 0,
                           mix_t typed_mix = '0);
    mix_t m;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (bank_step(cmd, d, m)) mix_q.push_back(typed ? typed_mix : m);
  endtask

  // writes one register and updates the model, leaving the write strobe high unless last is set
  task automatic write_reg(logic [1:0] sel, int val, bit last);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= 13'(val);
    @(posedge clk_i);
    cfg_writes++;
    case (sel)
      REG_ACTIVE: act_cnt = val & 9'h1ff;
      REG_BLEN:   blk_len = val & 13'h1fff;
      REG_THRESH: thr_lsb = val & 8'hff;
      default: ;
    endcase
    if (last) cfg_we_i <= 1'b0;
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (mix_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic row_t beat_row(logic [2:0] cmd, int idx, int x, int a, int b1, int b2,
                                    int sg, int dc, bit typed = 0, int ev = 0, bit ec = 0);
    row_t r;
    r = '{default: 0};
    r.cmd = cmd; r.idx = idx; r.x = x; r.a = a; r.b1 = b1; r.b2 = b2; r.sg = sg; r.dc = dc;
    r.typed = typed; r.exp_val = ev; r.exp_clip = ec;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] sel, int val);
    row_t r;
    r = '{default: 0};
    r.is_cfg = 1; r.reg_sel = sel; r.reg_val = val;
    return r;
  endfunction

  localparam int SMAX = 8388607;
  localparam int SMIN = -8388608;

  row_t   dir_rows[$];
  phase_t phases[8] = '{
    '{8, 1, 255, 0, 0, 240},
    '{3, 4096, 0, 57, 0, 240},
    '{16, 5, 40, 0, 57, 240},
    '{256, 8191, 7, 35, 35, 110},
    '{0, 2, 1, 57, 57, 90},
    '{300, 0, 255, 0, 0, 70},
    '{1, 1, 0, 35, 35, 240},
    '{32, 3, 128, 57, 0, 240}
  };

  // result side: random stall, scoreboard, watchdog
  always @(posedge clk_i) begin
    mix_t e;
    bit   moved;
    moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mixes_seen++;
      if (mix_q.size() == 0) begin
        errors++;
        $display("unexpected beat: sample_out=%0d clipped=%0b",
                 $signed(m_axis_tdata), m_axis_tuser);
      end else begin
        e = mix_q.pop_front();
        if (m_axis_tdata !== e.value || m_axis_tuser !== e.clip) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                     $signed(e.value), $signed(m_axis_tdata), e.clip, m_axis_tuser);
        end
      end
    end
    quiet = moved ? 0 : quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WD_LIMIT);
      $display("two_pole_resonator_bank_tb: errors");
      $finish;
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    row_t r;
    mix_t tm;
    int   pick;
    logic [2:0] cmd;
    logic [DIN_W-1:0] d;
    for (int i = 0; i < NFILT; i++) begin
      y1_st[i] = 0; y2_st[i] = 0;
      gain_c[i] = 0; fb1_c[i] = 0; fb2_c[i] = 0; strike_c[i] = 0; decay_c[i] = 0;
    end
    flush_ptr = 0; blk_cnt = 0; act_cnt = 0; blk_len = 64; thr_lsb = 1;

    // reset values, then the default unity filter 0
    dir_rows.push_back(beat_row(CMD_SAMPLE, 0, SMAX, 0, 0, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(beat_row(3'd5, 255, SMIN, -1, -1, -1, -1, 16777215));
    dir_rows.push_back(beat_row(3'd7, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_STRIKE, 0, SMAX, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_SQUELCH, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_ACTIVE, 1));
    dir_rows.push_back(beat_row(CMD_COEF, 0, 0, 4194304, 0, 0, 1048576, 16777215));
    dir_rows.push_back(beat_row(CMD_SAMPLE, 0, SMAX, 0, 0, 0, 0, 0, 1, SMAX, 0));
    dir_rows.push_back(beat_row(CMD_SAMPLE, 0, SMIN, 0, 0, 0, 0, 0, 1, SMIN, 0));
    dir_rows.push_back(beat_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(beat_row(CMD_STRIKE, 0, SMAX, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_COEF, 0, 0, SMAX, SMAX, SMIN, SMIN, 16777215));
    dir_rows.push_back(beat_row(CMD_SAMPLE, 0, SMAX, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_SQUELCH, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_SAMPLE, 0, SMIN, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_STRIKE, 0, SMIN, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_COEF, 200, 0, SMIN, SMIN, SMAX, SMAX, 0));
    dir_rows.push_back(cfg_row(REG_ACTIVE, 300));
    dir_rows.push_back(beat_row(CMD_SAMPLE, 0, SMAX, 0, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_BLEN, 0));
    dir_rows.push_back(cfg_row(REG_THRESH, 255));
    dir_rows.push_back(beat_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(beat_row(CMD_SAMPLE, 0, 1, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every coefficient entry gets written while no filter is active
    for (int i = 0; i < NFILT; i++) send_beat(CMD_COEF, stable_coef(i));

    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      if (r.is_cfg) begin
        quiesce();
        write_reg(r.reg_sel, r.reg_val, 1);
      end else begin
        tm.value = 24'(r.exp_val);
        tm.clip = r.exp_clip;
        send_beat(r.cmd, pack_beat(r.idx, r.x, r.a, r.b1, r.b2, r.sg, r.dc), r.typed, tm);
      end
    end

    foreach (phases[p]) begin
      quiesce();
      send_idle = phases[p].sidle;
      recv_stall = phases[p].rstall;
      write_reg(REG_ACTIVE, phases[p].act, 0);
      write_reg(REG_BLEN, phases[p].blen, 0);
      write_reg(REG_THRESH, phases[p].thr, 1);
      for (int k = 0; k < phases[p].n; k++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          cmd = CMD_SAMPLE;
          d = pack_beat($urandom, ($urandom_range(3) == 0) ? $urandom : 0,
                        $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 78) begin
          cmd = CMD_COEF;
          d = stable_coef($urandom_range(255));
        end else if (pick < 81) begin
          cmd = CMD_COEF;
          d = pack_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
        end else if (pick < 88) begin
          cmd = CMD_STRIKE;
          d = pack_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
        end else if (pick < 92) begin
          cmd = CMD_CLEAR;
          d = pack_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
        end else if (pick < 96) begin
          cmd = CMD_SQUELCH;
          d = pack_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
        end else begin
          cmd = 3'($urandom_range(7, 5));
          d = pack_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
        end
        send_beat(cmd, d);
      end
    end

    quiesce();
    if (mix_q.size() != 0) errors++;
    $display("covered %0d input beats and %0d register writes over %0d settings",
             beats_sent, cfg_writes, $size(phases) + 1);
    $display("checked %0d mixed samples, %0d mismatching", mixes_seen, mismatches);
    if (errors == 0) begin
      $display("two_pole_resonator_bank_tb: clean");
    end else begin
      $display("two_pole_resonator_bank_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tprb_pkg.sv
rtl/tprb_datapath.sv
rtl/two_pole_resonator_bank.sv
tb/two_pole_resonator_bank_tb.sv
